// File: rtl/quality_context_channel_update_core_macros.svh
// Assertion macros shared by the quality context channel update RTL.
// Stands alone; the including module supplies the clock and reset names.
`ifndef QUALITY_CONTEXT_CHANNEL_UPDATE_CORE_MACROS_SVH
`define QUALITY_CONTEXT_CHANNEL_UPDATE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QCCU_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QCCU_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/qccu_pkg.sv
// Package for the quality context channel update core: field widths,
// opcodes, sequencer states and fixed table constants. No dependencies.
package qccu_pkg;

    localparam int OPCODE_W    = 2;
    localparam int BASE_W      = 2;
    localparam int QUAL_W      = 7;
    localparam int BIN_W       = 5;
    localparam int CHANNEL_W   = 16;
    localparam int BASES_OUT_W = 12;

    localparam int DELTA_W   = 4;
    localparam int QBIN_W    = 5;
    localparam int ECLASS_W  = 2;
    localparam int QIDX_BITS = DELTA_W + QBIN_W;
    localparam int SUM_W     = 16;
    localparam int TOT_W     = 32;
    // Width of a 16-bit sum after a rounding divide by sixteen.
    localparam int RND_W     = 13;

    localparam logic [DELTA_W-1:0] DELTA_CAP = 4'd15;
    localparam logic [TOT_W-1:0]   TOT_RESET = 32'h1010_1010;

    localparam logic [OPCODE_W-1:0] OP_PROCESS   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BIN_WRITE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR     = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NOP       = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_CLASS,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/qccu_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read-first on a same-address collision. No dependencies.
module qccu_ram #(
    parameter int ADDR_BITS = 9,
    parameter int DEPTH     = 512,
    parameter int WIDTH     = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/quality_context_channel_update_core.sv
// Quality score context model update core (top level).
// Depends on qccu_pkg, qccu_ram and quality_context_channel_update_core_macros.svh.
//
// Usage:
// The input channel (in_valid/in_ready) carries one beat per command: process a
// quality value, write a bin table entry, clear the context for a new read, or
// do nothing. Every input beat yields exactly one output beat on out_valid/
// out_ready, carrying the context after the command: channel holds delta,
// quality bin, average bin and error class, context_bases the base history.
// A one-beat input buffer takes the next command while the current one is at
// work, and an output register holds a finished beat while the next command runs.
// Steps: a process beat passes through the sequencer in order (read the old
// context entries, update and write them back while reading the new entries,
// classify and look up the average bin, finish); other commands go straight to finish.
// Back to back, a new command starts as the one before it retires. Process beats
// are paced by the read-modify-write loop on the statistics memories, since each
// beat addresses them through the context left by the beat before it.
// Reset: the context clears at once, then a clearing pass walks every entry
// of the statistics memory, 2^(2*BASES_IN_CONTEXT+9) entries (2^21 by default),
// with in_ready low; the total error memory is set during the same pass.
// The bin table is not cleared; it must be written before it is used.
// Output stall: a finished beat waits in the output register, the sequencer
// holds its last step, and the input buffer keeps at most one waiting beat.
`include "quality_context_channel_update_core_macros.svh"

module quality_context_channel_update_core #(
    parameter int BASES_IN_CONTEXT = 6,
    parameter int BIN_TABLE_DEPTH  = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [qccu_pkg::OPCODE_W-1:0]      opcode,
    input  logic [qccu_pkg::BASE_W-1:0]        base_code,
    input  logic [qccu_pkg::QUAL_W-1:0]        quality,
    input  logic [qccu_pkg::QUAL_W-1:0]        previous_quality,
    input  logic [qccu_pkg::BIN_W-1:0]         bin_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [qccu_pkg::CHANNEL_W-1:0]     channel,
    output logic [qccu_pkg::BASES_OUT_W-1:0]   context_bases
);

    import qccu_pkg::*;

    // Context layout, low to high: bases, delta, quality bin, average bin, error class.
    // The low STAT_AW bits form the statistics memory index; the delta and quality
    // bin together form the total error memory index.
    localparam int B_BITS    = 2 * BASES_IN_CONTEXT;
    localparam int STAT_AW   = B_BITS + QIDX_BITS;
    localparam int CTX_BITS  = STAT_AW + QBIN_W + ECLASS_W;
    localparam int NCTX_SIZE = 1 << STAT_AW;
    localparam int QIDX_SIZE = 1 << QIDX_BITS;
    localparam int BIN_AW    = $clog2(BIN_TABLE_DEPTH);
    localparam logic [RND_W-1:0] BIN_LAST = RND_W'(BIN_TABLE_DEPTH - 1);

    // Bin table addresses beyond the last entry use the last entry.
    function automatic logic [BIN_AW-1:0] bin_addr(input logic [RND_W-1:0] v);
        logic [BIN_AW-1:0] a;
        if (v > BIN_LAST)
        begin
            a = BIN_LAST[BIN_AW-1:0];
        end
        else
        begin
            a = v[BIN_AW-1:0];
        end
        return a;
    endfunction

    state_t state_reg, state_next;

    // Input buffer.
    logic                 buf_valid_reg, buf_valid_next;
    logic [OPCODE_W-1:0]  buf_op_reg;
    logic [BASE_W-1:0]    buf_base_reg;
    logic [QUAL_W-1:0]    buf_q1_reg;
    logic [QUAL_W-1:0]    buf_q2_reg;
    logic [BIN_W-1:0]     buf_bin_reg;

    // Command at work.
    logic [OPCODE_W-1:0]  work_op_reg;
    logic [BASE_W-1:0]    work_base_reg;
    logic [QUAL_W-1:0]    work_q1_reg;
    logic [QUAL_W-1:0]    work_q2_reg;
    logic [STAT_AW-1:0]   old_n_reg;

    // Values carried from the update and classify steps to the steps after them.
    logic [STAT_AW-1:0]     new_n_reg;
    logic [2*SUM_W-1:0]     upd_sum_reg;
    logic [TOT_W-1:0]       upd_tot_reg;
    logic                   hit_n_reg;
    logic                   hit_q_reg;
    logic [ECLASS_W-1:0]    ec_reg;

    logic [CTX_BITS-1:0]    ctx_reg;
    logic [CTX_BITS-1:0]    ctx_next;
    logic [STAT_AW-1:0]     clr_cnt_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [CHANNEL_W-1:0]   channel_reg;
    logic [BASES_OUT_W-1:0] bases_reg;

    logic start;
    logic finish_ok;
    logic finish_fire;
    logic [STAT_AW-1:0] start_n;

    // Memory ports.
    logic                 sum_we, sum_re;
    logic [STAT_AW-1:0]   sum_waddr, sum_raddr;
    logic [2*SUM_W-1:0]   sum_wdata, sum_rdata;
    logic                 tot_we, tot_re;
    logic [QIDX_BITS-1:0] tot_waddr, tot_raddr;
    logic [TOT_W-1:0]     tot_wdata, tot_rdata;
    logic                 bin_we, bin_re;
    logic [BIN_AW-1:0]    bin_waddr, bin_raddr;
    logic [BIN_W-1:0]     bin_wdata, bin_rdata;

    // Update step arithmetic.
    logic [SUM_W-1:0]     a_old, e_old;
    logic [SUM_W:0]       a_rnd_w, e_rnd_w;
    logic [RND_W-1:0]     a_rnd, e_rnd, q1_w;
    logic [RND_W-1:0]     abs_err;
    logic [SUM_W-1:0]     avg_new, err_new;
    logic [TOT_W:0]       t_rnd_w;
    logic [TOT_W-1:0]     tot_new;
    logic [QUAL_W-1:0]    dmag;
    logic [QUAL_W:0]      zw;
    logic [DELTA_W-1:0]   z;
    logic [B_BITS+1:0]    nb_w;
    logic [STAT_AW-1:0]   new_n;

    // Classify step arithmetic.
    logic [2*SUM_W-1:0]   sum_v;
    logic [TOT_W-1:0]     tot_v;
    logic [SUM_W:0]       avg_rnd_w;
    logic [TOT_W:0]       ae_w, t_w, t_half, t_dbl;
    logic [ECLASS_W-1:0]  ec;

    qccu_ram #(
        .ADDR_BITS (STAT_AW),
        .DEPTH     (NCTX_SIZE),
        .WIDTH     (2 * SUM_W)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    qccu_ram #(
        .ADDR_BITS (QIDX_BITS),
        .DEPTH     (QIDX_SIZE),
        .WIDTH     (TOT_W)
    ) u_tot_ram (
        .clk   (clk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .re    (tot_re),
        .raddr (tot_raddr),
        .rdata (tot_rdata)
    );

    qccu_ram #(
        .ADDR_BITS (BIN_AW),
        .DEPTH     (BIN_TABLE_DEPTH),
        .WIDTH     (BIN_W)
    ) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .re    (bin_re),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    // Handshake and sequencing.
    assign in_ready    = !buf_valid_reg && (state_reg != ST_CLEAR);
    assign finish_ok   = !out_valid_reg || out_ready;
    assign finish_fire = (state_reg == ST_FINISH) && finish_ok;
    // A new command starts from idle, or in the same cycle the last one retires.
    assign start = buf_valid_reg && ((state_reg == ST_IDLE) || finish_fire);
    // When starting on a retiring command, its new context indexes the reads.
    assign start_n = (state_reg == ST_FINISH) ? ctx_next[STAT_AW-1:0]
                                              : ctx_reg[STAT_AW-1:0];

    assign buf_valid_next = (in_valid && in_ready) ? 1'b1 :
                            (start ? 1'b0 : buf_valid_reg);
    assign out_valid_next = finish_fire ? 1'b1 :
                            (out_ready ? 1'b0 : out_valid_reg);

    // Update step: the read data belongs to the old context entries.
    always_comb
    begin
        a_old   = sum_rdata[SUM_W-1:0];
        e_old   = sum_rdata[2*SUM_W-1:SUM_W];
        a_rnd_w = {1'b0, a_old} + (SUM_W + 1)'(8);
        a_rnd   = a_rnd_w[SUM_W:4];
        e_rnd_w = {1'b0, e_old} + (SUM_W + 1)'(8);
        e_rnd   = e_rnd_w[SUM_W:4];
        q1_w    = RND_W'(work_q1_reg);
        if (a_rnd > q1_w)
        begin
            abs_err = a_rnd - q1_w;
        end
        else
        begin
            abs_err = q1_w - a_rnd;
        end
        avg_new = a_old + SUM_W'(q1_w) - SUM_W'(a_rnd);
        err_new = e_old + SUM_W'(abs_err) - SUM_W'(e_rnd);
        t_rnd_w = {1'b0, tot_rdata} + (TOT_W + 1)'(8);
        tot_new = tot_rdata + TOT_W'(abs_err) - TOT_W'(t_rnd_w[TOT_W:4]);

        // Zigzag delta: positive steps even, negative steps odd.
        if (work_q1_reg >= work_q2_reg)
        begin
            dmag = work_q1_reg - work_q2_reg;
            zw   = {dmag, 1'b0};
        end
        else
        begin
            dmag = work_q2_reg - work_q1_reg;
            zw   = {dmag, 1'b0} - (QUAL_W + 1)'(1);
        end
        if (zw > (QUAL_W + 1)'(DELTA_CAP))
        begin
            z = DELTA_CAP;
        end
        else
        begin
            z = zw[DELTA_W-1:0];
        end
        nb_w  = {old_n_reg[B_BITS-1:0], work_base_reg};
        new_n = {bin_rdata, z, nb_w[B_BITS-1:0]};
    end

    // Classify step: the new entries, with the just-written values forwarded
    // when the new index equals the old one.
    always_comb
    begin
        sum_v     = hit_n_reg ? upd_sum_reg : sum_rdata;
        tot_v     = hit_q_reg ? upd_tot_reg : tot_rdata;
        avg_rnd_w = {1'b0, sum_v[SUM_W-1:0]} + (SUM_W + 1)'(8);
        ae_w      = (TOT_W + 1)'(sum_v[2*SUM_W-1:SUM_W]);
        t_w       = {1'b0, tot_v};
        t_half    = t_w >> 1;
        t_dbl     = t_w << 1;
        if (ae_w < t_half)
        begin
            ec = 2'd0;
        end
        else if (ae_w < t_w)
        begin
            ec = 2'd1;
        end
        else if (ae_w < t_dbl)
        begin
            ec = 2'd2;
        end
        else
        begin
            ec = 2'd3;
        end
    end

    // Context after the command in the finish step.
    always_comb
    begin
        case (work_op_reg)
            OP_PROCESS:   ctx_next = {ec_reg, bin_rdata, new_n_reg};
            OP_CLEAR:     ctx_next = '0;
            OP_BIN_WRITE: ctx_next = ctx_reg;
            default:      ctx_next = ctx_reg;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (buf_op_reg == OP_PROCESS) ? ST_UPDATE : ST_FINISH;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (start)
                begin
                    state_next = (buf_op_reg == OP_PROCESS) ? ST_UPDATE : ST_FINISH;
                end
                else if (finish_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port control.
    always_comb
    begin
        sum_we    = 1'b0;
        sum_waddr = old_n_reg;
        sum_wdata = {err_new, avg_new};
        sum_re    = 1'b0;
        sum_raddr = start_n;
        tot_we    = 1'b0;
        tot_waddr = old_n_reg[STAT_AW-1:B_BITS];
        tot_wdata = tot_new;
        tot_re    = 1'b0;
        tot_raddr = start_n[STAT_AW-1:B_BITS];
        bin_we    = 1'b0;
        bin_waddr = bin_addr(RND_W'(buf_q1_reg));
        bin_wdata = buf_bin_reg;
        bin_re    = 1'b0;
        bin_raddr = bin_addr(RND_W'(buf_q1_reg));
        case (state_reg)
            ST_CLEAR:
            begin
                // Average sums start at sixteen times the quality bin of the index.
                sum_we    = 1'b1;
                sum_waddr = clr_cnt_reg;
                sum_wdata = {{SUM_W{1'b0}},
                             SUM_W'({clr_cnt_reg[STAT_AW-1 -: QBIN_W], 4'b0000})};
                tot_we    = 1'b1;
                tot_waddr = clr_cnt_reg[QIDX_BITS-1:0];
                tot_wdata = TOT_RESET;
            end
            ST_UPDATE:
            begin
                sum_we    = 1'b1;
                tot_we    = 1'b1;
                sum_re    = 1'b1;
                sum_raddr = new_n;
                tot_re    = 1'b1;
                tot_raddr = new_n[STAT_AW-1:B_BITS];
            end
            ST_CLASS:
            begin
                bin_re    = 1'b1;
                bin_raddr = bin_addr(avg_rnd_w[SUM_W:4]);
            end
            default:
            begin
            end
        endcase
        if (start)
        begin
            sum_re = 1'b1;
            tot_re = 1'b1;
            bin_re = 1'b1;
            bin_we = (buf_op_reg == OP_BIN_WRITE);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
            if (finish_fire)
            begin
                ctx_reg <= ctx_next;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + STAT_AW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            buf_op_reg   <= opcode;
            buf_base_reg <= base_code;
            buf_q1_reg   <= quality;
            buf_q2_reg   <= previous_quality;
            buf_bin_reg  <= bin_value;
        end
        if (start)
        begin
            work_op_reg   <= buf_op_reg;
            work_base_reg <= buf_base_reg;
            work_q1_reg   <= buf_q1_reg;
            work_q2_reg   <= buf_q2_reg;
            old_n_reg     <= start_n;
        end
        if (state_reg == ST_UPDATE)
        begin
            new_n_reg   <= new_n;
            upd_sum_reg <= {err_new, avg_new};
            upd_tot_reg <= tot_new;
            hit_n_reg   <= (new_n == old_n_reg);
            hit_q_reg   <= (new_n[STAT_AW-1:B_BITS] == old_n_reg[STAT_AW-1:B_BITS]);
        end
        if (state_reg == ST_CLASS)
        begin
            ec_reg <= ec;
        end
        if (finish_fire)
        begin
            channel_reg <= ctx_next[CTX_BITS-1:B_BITS];
            bases_reg   <= BASES_OUT_W'(ctx_next[B_BITS-1:0]);
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel       = channel_reg;
    assign context_bases = bases_reg;

    `QCCU_ASSERT_SAME(a_no_accept_in_clear, clk, rst_n, state_reg == ST_CLEAR, !in_ready, "input accepted during clearing pass")
    `QCCU_ASSERT_SAME(a_sum_write_state, clk, rst_n, sum_we, (state_reg == ST_UPDATE || state_reg == ST_CLEAR), "statistics memory written outside update or clear")
    `QCCU_ASSERT_SAME(a_update_is_process, clk, rst_n, state_reg == ST_UPDATE, work_op_reg == OP_PROCESS, "update step for a command that is not process")
    `QCCU_ASSERT_NEXT(a_update_to_class, clk, rst_n, state_reg == ST_UPDATE, state_reg == ST_CLASS, "update step not followed by classify step")
    `QCCU_ASSERT_NEXT(a_finish_shows, clk, rst_n, finish_fire, out_valid, "retired command did not reach the output register")

endmodule

// File: tb/quality_context_channel_update_core_tb.sv
// Self-checking testbench for quality_context_channel_update_core.
// Depends on qccu_pkg and the core RTL; a predictor written here supplies the
// expected context for every command beat and a monitor compares the results.
module quality_context_channel_update_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qccu_pkg::*;

    // Context word layout: base history, then delta, quality bin, average bin
    // and error class. The low STAT_AW bits index the statistics memories.
    localparam int BASES_IN_CONTEXT = 6;
    localparam int BIN_TABLE_DEPTH  = 128;
    localparam int B_BITS           = 2 * BASES_IN_CONTEXT;
    localparam int STAT_AW          = B_BITS + QIDX_BITS;
    localparam int CTX_W            = STAT_AW + QBIN_W + ECLASS_W;
    localparam int QIDX_SIZE        = 1 << QIDX_BITS;

    // The clearing pass after reset walks the whole statistics memory, so the
    // cycle limit is dominated by it; the rest covers the command traffic
    // with every gap and stall at its longest.
    localparam longint CYCLE_LIMIT = 4 * (longint'(1) << STAT_AW) + 400_000;

    typedef struct packed {
        logic [CHANNEL_W-1:0]   channel;
        logic [BASES_OUT_W-1:0] bases;
    } ctx_result_t;

    logic                   clk              = 1'b0;
    logic                   rst_n            = 1'b0;
    logic                   in_valid         = 1'b0;
    logic                   in_ready;
    logic [OPCODE_W-1:0]    opcode           = OP_NOP;
    logic [BASE_W-1:0]      base_code        = '0;
    logic [QUAL_W-1:0]      quality          = '0;
    logic [QUAL_W-1:0]      previous_quality = '0;
    logic [BIN_W-1:0]       bin_value        = '0;
    logic                   out_valid;
    logic                   out_ready        = 1'b1;
    logic [CHANNEL_W-1:0]   channel;
    logic [BASES_OUT_W-1:0] context_bases;

    // Random idling on both sides is switched off for the last part of the run.
    bit     idle_on     = 1'b1;
    int     stall_left  = 0;
    int     fail_count  = 0;
    int     beat_count  = 0;
    longint cycle_count = 0;

    // Predictor state: context word, sparse statistics memories (entries that
    // were never touched read as their reset value), total error memory and
    // the bin table.
    logic [CTX_W-1:0]   ctx_word;
    logic [SUM_W-1:0]   avg_sums [int unsigned];
    logic [SUM_W-1:0]   err_sums [int unsigned];
    logic [TOT_W-1:0]   total_err [QIDX_SIZE];
    logic [BIN_W-1:0]   bin_map [BIN_TABLE_DEPTH];

    // Contexts still owed by the block, oldest first.
    ctx_result_t pending_contexts[$];

    quality_context_channel_update_core #(
        .BASES_IN_CONTEXT(BASES_IN_CONTEXT),
        .BIN_TABLE_DEPTH (BIN_TABLE_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .base_code       (base_code),
        .quality         (quality),
        .previous_quality(previous_quality),
        .bin_value       (bin_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .channel         (channel),
        .context_bases   (context_bases)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Divide by sixteen with rounding, wide enough that nothing overflows.
    function automatic longint unsigned round16(input longint unsigned x);
        return (x + 8) >> 4;
    endfunction

    // Bin table read; addresses past the end clamp to the last entry.
    function automatic logic [BIN_W-1:0] bin_lookup(input longint unsigned idx);
        if (idx > BIN_TABLE_DEPTH - 1)
        begin
            idx = BIN_TABLE_DEPTH - 1;
        end
        return bin_map[idx];
    endfunction

    // An untouched average entry starts at its quality bin field times sixteen.
    function automatic int avg_read(input int unsigned n);
        if (avg_sums.exists(n))
        begin
            return avg_sums[n];
        end
        return ((n >> (B_BITS + DELTA_W)) & 31) << 4;
    endfunction

    function automatic int err_read(input int unsigned n);
        if (err_sums.exists(n))
        begin
            return err_sums[n];
        end
        return 0;
    endfunction

    function automatic void clear_context_model();
        ctx_word = '0;
        avg_sums.delete();
        err_sums.delete();
        foreach (total_err[i])
        begin
            total_err[i] = TOT_RESET;
        end
        foreach (bin_map[i])
        begin
            bin_map[i] = '0;
        end
    endfunction

    // One quality step: update the statistics at the old context, then build
    // the new context and classify its error against the total error average.
    function automatic void process_quality(input logic [BASE_W-1:0] b,
                                            input logic [QUAL_W-1:0] q1,
                                            input logic [QUAL_W-1:0] q2);
        int unsigned      old_n;
        int unsigned      old_q;
        int unsigned      new_n;
        int unsigned      new_q;
        int               a;
        int               e;
        int               err;
        int               abs_err;
        int               d;
        int               z;
        longint unsigned  t;
        longint unsigned  tavg;
        longint unsigned  ae;
        logic [BIN_W-1:0] qb;
        logic [BIN_W-1:0] avg_bin;
        logic [1:0]       eclass;

        old_n = ctx_word[STAT_AW-1:0];
        old_q = ctx_word[STAT_AW-1:B_BITS];

        a = avg_read(old_n);
        err = int'(q1) - int'(round16(a));
        abs_err = (err < 0) ? -err : err;
        avg_sums[old_n] = SUM_W'(a + err);
        e = err_read(old_n);
        err_sums[old_n] = SUM_W'(e + abs_err - int'(round16(e)));
        t = total_err[old_q];
        total_err[old_q] = TOT_W'(t + abs_err - round16(t));

        // Zigzag delta: positive steps map to even codes, negative to odd.
        d = int'(q1) - int'(q2);
        z = (d < 0) ? (-d * 2 - 1) : (d * 2);
        if (z > int'(DELTA_CAP))
        begin
            z = int'(DELTA_CAP);
        end
        qb = bin_lookup(q1);

        new_n = {qb, z[DELTA_W-1:0], ctx_word[B_BITS-3:0], b};
        new_q = {qb, z[DELTA_W-1:0]};
        avg_bin = bin_lookup(round16(avg_read(new_n)));

        tavg = total_err[new_q];
        ae = err_read(new_n);
        if (ae < (tavg >> 1))
        begin
            eclass = 2'd0;
        end
        else if (ae < tavg)
        begin
            eclass = 2'd1;
        end
        else if (ae < (tavg << 1))
        begin
            eclass = 2'd2;
        end
        else
        begin
            eclass = 2'd3;
        end

        ctx_word = {eclass, avg_bin, new_n[STAT_AW-1:0]};
    endfunction

    function automatic int unsigned bin_lookup_addr(input int unsigned idx);
        return (idx > BIN_TABLE_DEPTH - 1) ? BIN_TABLE_DEPTH - 1 : idx;
    endfunction

    // Applies one command to the predictor and returns the context it reports.
    function automatic ctx_result_t update_context(input logic [OPCODE_W-1:0] op,
                                                   input logic [BASE_W-1:0]   b,
                                                   input logic [QUAL_W-1:0]   q1,
                                                   input logic [QUAL_W-1:0]   q2,
                                                   input logic [BIN_W-1:0]    bv);
        ctx_result_t r;
        case (op)
            OP_PROCESS:   process_quality(b, q1, q2);
            OP_BIN_WRITE: bin_map[bin_lookup_addr(q1)] = bv;
            OP_CLEAR:     ctx_word = '0;
            default:      ;
        endcase
        r.channel = ctx_word[B_BITS +: CHANNEL_W];
        r.bases   = ctx_word[B_BITS-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40)
        begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
        end
        fail_count++;
    endtask

    // Drives one command beat from a falling edge and holds it until the block
    // takes it. Valid stays high after the beat so that a back-to-back beat
    // never lowers and raises it in one time step; idle_bus lowers it.
    task automatic send_beat(input logic [OPCODE_W-1:0] op,
                             input logic [BASE_W-1:0]   b,
                             input logic [QUAL_W-1:0]   q1,
                             input logic [QUAL_W-1:0]   q2,
                             input logic [BIN_W-1:0]    bv);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid         <= 1'b1;
        opcode           <= op;
        base_code        <= b;
        quality          <= q1;
        previous_quality <= q2;
        bin_value        <= bv;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        pending_contexts.push_back(update_context(op, b, q1, q2, bv));
        beat_count++;
    endtask

    task automatic idle_bus();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Holds the sender off until every owed context has come back.
    task automatic wait_drained();
        idle_bus();
        while (pending_contexts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic int clamp_quality(input int q);
        return (q < 0) ? 0 : ((q > 127) ? 127 : q);
    endfunction

    // One read: a clear, then a run of process beats whose previous quality is
    // the quality of the beat before, starting from zero. Base and quality
    // patterns are chosen so that contexts recur and the statistics build up.
    // Noise beats, table rewrites and no-ops are scattered in between.
    task automatic send_read(input int len);
        int         q;
        int         prev_q;
        int         level;
        int         base_mode;
        int         qual_mode;
        logic [3:0] pattern;
        logic [1:0] b;

        send_beat(OP_CLEAR, BASE_W'($urandom_range(0, 3)), QUAL_W'($urandom_range(0, 127)),
                  QUAL_W'($urandom_range(0, 127)), BIN_W'($urandom_range(0, 31)));
        base_mode = $urandom_range(0, 2);
        qual_mode = $urandom_range(0, 2);
        pattern   = 4'($urandom_range(0, 15));
        level     = $urandom_range(0, 127);
        q         = 0;
        prev_q    = 0;
        for (int i = 0; i < len; i++)
        begin
            if (i != 0)
            begin
                case (qual_mode)
                    0:       q = clamp_quality(level + $urandom_range(0, 6) - 3);
                    1:       q = $urandom_range(0, 127);
                    default: q = clamp_quality(q + $urandom_range(0, 4) - 2);
                endcase
            end
            case (base_mode)
                0:       b = pattern[1:0];
                1:       b = i[0] ? pattern[3:2] : pattern[1:0];
                default: b = BASE_W'($urandom_range(0, 3));
            endcase
            if ($urandom_range(0, 24) == 0)
            begin
                // Any command with any fields, which may break the read.
                send_beat(OPCODE_W'($urandom_range(0, 3)), BASE_W'($urandom_range(0, 3)),
                          QUAL_W'($urandom_range(0, 127)), QUAL_W'($urandom_range(0, 127)),
                          BIN_W'($urandom_range(0, 31)));
            end
            if ($urandom_range(0, 39) == 0)
            begin
                send_beat(OP_BIN_WRITE, BASE_W'($urandom_range(0, 3)),
                          QUAL_W'($urandom_range(0, 127)), QUAL_W'($urandom_range(0, 127)),
                          BIN_W'($urandom_range(0, 31)));
            end
            if ($urandom_range(0, 49) == 0)
            begin
                send_beat(OP_NOP, BASE_W'($urandom_range(0, 3)),
                          QUAL_W'($urandom_range(0, 127)), QUAL_W'($urandom_range(0, 127)),
                          BIN_W'($urandom_range(0, 31)));
            end
            send_beat(OP_PROCESS, b, QUAL_W'(q), QUAL_W'(prev_q), BIN_W'($urandom_range(0, 31)));
            prev_q = q;
        end
    endtask

    // Receiver side: ready changes only at the falling edge, in random stall
    // bursts while idling is on.
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: every accepted result beat is matched against the oldest
    // owed context, one field at a time.
    always @(posedge clk)
    begin
        ctx_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_contexts.size() == 0)
            begin
                report_mismatch("unexpected result beat", channel, 0);
            end
            else
            begin
                want = pending_contexts.pop_front();
                if (channel !== want.channel)
                begin
                    report_mismatch("channel", channel, want.channel);
                end
                if (context_bases !== want.bases)
                begin
                    report_mismatch("context_bases", context_bases, want.bases);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("quality_context_channel_update_core_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every bin entry is loaded before any process beat can read it. A
    // coarse map of four qualities per bin keeps quality bins recurring and
    // puts 0 in the first entry and 31 in the last.
    task automatic test_bin_table_load();
        for (int a = 0; a < BIN_TABLE_DEPTH; a++)
        begin
            send_beat(OP_BIN_WRITE, BASE_W'($urandom_range(0, 3)), QUAL_W'(a),
                      QUAL_W'($urandom_range(0, 127)), BIN_W'(a >> 2));
        end
    endtask

    // Field extremes, every opcode, the zigzag cap in both directions and the
    // start-of-read rule.
    task automatic test_directed_cases();
        send_beat(OP_CLEAR,     2'd0, 7'd0,   7'd0,   5'd0);
        send_beat(OP_PROCESS,   2'd0, 7'd0,   7'd0,   5'd0);
        send_beat(OP_PROCESS,   2'd3, 7'd127, 7'd0,   5'd31);
        send_beat(OP_PROCESS,   2'd1, 7'd0,   7'd127, 5'd0);
        send_beat(OP_PROCESS,   2'd2, 7'd64,  7'd64,  5'd21);
        send_beat(OP_PROCESS,   2'd0, 7'd65,  7'd64,  5'd10);
        send_beat(OP_PROCESS,   2'd1, 7'd63,  7'd64,  5'd0);
        send_beat(OP_PROCESS,   2'd2, 7'd71,  7'd64,  5'd0);
        send_beat(OP_PROCESS,   2'd3, 7'd56,  7'd64,  5'd0);
        send_beat(OP_PROCESS,   2'd0, 7'd57,  7'd64,  5'd0);
        send_beat(OP_NOP,       2'd3, 7'd127, 7'd127, 5'd31);
        // Swap the extreme table entries and read them back.
        send_beat(OP_BIN_WRITE, 2'd0, 7'd0,   7'd0,   5'd31);
        send_beat(OP_BIN_WRITE, 2'd0, 7'd127, 7'd0,   5'd0);
        send_beat(OP_PROCESS,   2'd1, 7'd127, 7'd0,   5'd0);
        send_beat(OP_PROCESS,   2'd2, 7'd0,   7'd0,   5'd0);
        send_beat(OP_NOP,       2'd0, 7'd0,   7'd0,   5'd0);
        send_beat(OP_CLEAR,     2'd3, 7'd127, 7'd127, 5'd31);
        send_beat(OP_BIN_WRITE, 2'd0, 7'd0,   7'd0,   5'd0);
        send_beat(OP_BIN_WRITE, 2'd0, 7'd127, 7'd0,   5'd31);
        send_beat(OP_PROCESS,   2'd3, 7'd0,   7'd0,   5'd0);
        send_beat(OP_PROCESS,   2'd3, 7'd127, 7'd0,   5'd0);
        send_beat(OP_PROCESS,   2'd3, 7'd127, 7'd127, 5'd0);
    endtask

    // The bulk of the traffic: reads of mixed length with idling on both sides.
    task automatic test_random_reads(input int target);
        while (beat_count < target)
        begin
            send_read($urandom_range(1, 48));
        end
    endtask

    // The sender stops until the block has answered everything, then resumes.
    task automatic test_drained_pauses();
        repeat (4)
        begin
            send_read($urandom_range(4, 24));
            wait_drained();
        end
    endtask

    // Back-to-back beats and an always-ready receiver for the last stretch.
    task automatic test_back_to_back(input int target);
        idle_on = 1'b0;
        while (beat_count < target)
        begin
            send_read($urandom_range(8, 40));
        end
    endtask

    initial
    begin
        clear_context_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bin_table_load();
        test_directed_cases();
        test_random_reads(1300);
        test_drained_pauses();
        test_random_reads(1450);
        test_back_to_back(1800);

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("quality_context_channel_update_core_tb OK");
        end
        else
        begin
            $display("quality_context_channel_update_core_tb NOT OK");
        end
        $finish;
    end

endmodule
